FILE: src/rmss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmss_pkg
// Shared types for the rate-monotonic scheduler with sporadic server.
// ----------------------------------------------------------------------------
package rmss_pkg;

	localparam int unsigned CAP_W = 8;
	localparam int unsigned PER_W = 8;

	typedef enum logic [1:0] {
		REG_FULL_CAPACITY = 2'd0,
		REG_SERVER_PERIOD = 2'd1
	} reg_index_t;

	// Controller state, one-hot
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_ADMIT  = 6'b000010,
		ST_REFILL = 6'b000100,
		ST_SELECT = 6'b001000,
		ST_RUN    = 6'b010000,
		ST_DEAD   = 6'b100000
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;        // write slot from input word
		logic clr_scan;    // start a slot sweep
		logic admit_step;  // admission for scan slot
		logic refill;      // server replenishment
		logic select_step; // selection for scan slot
		logic run;         // time advance and execution
		logic dead_step;   // deadline check for scan slot
		logic emit;        // latch result
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_last;
	} dp_stat_t;

endpackage

FILE: src/rmss_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmss_datapath
// Slot state, server state and one-slot-per-cycle sweep logic.
// ----------------------------------------------------------------------------
module rmss_datapath import rmss_pkg::*; #(
	parameter int unsigned MAX_TASKS = 8,
	parameter int unsigned TIME_BITS = 16,
	parameter int unsigned SLOT_W    = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	input  logic [SLOT_W-1:0]    in_slot,
	input  logic [7:0]           in_exec,
	input  logic [7:0]           in_period,
	input  logic [15:0]          in_arrival,
	input  logic                 in_periodic,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_idx,
	input  logic [7:0]           cfg_data,
	output logic [TIME_BITS-1:0] now_tick,
	output logic                 ran_valid,
	output logic [SLOT_W-1:0]    ran_slot,
	output logic                 ran_aperiodic,
	output logic [MAX_TASKS-1:0] miss_mask,
	output logic [7:0]           capacity_now,
	output logic                 replenished
);

	localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
	localparam int unsigned WIDE  = TIME_BITS + 1;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
	localparam logic [WIDE-1:0] WIDE_MAX = {WIDE{1'b1}};

	logic [MAX_TASKS-1:0] loaded_q, admitted_q, periodic_q;
	logic [7:0]           exec_q     [MAX_TASKS];
	logic [7:0]           period_q   [MAX_TASKS];
	logic [15:0]          arrival_q  [MAX_TASKS];
	logic [IDX_W-1:0]     rank_q     [MAX_TASKS];
	logic [7:0]           work_q     [MAX_TASKS];
	logic [WIDE-1:0]      deadline_q [MAX_TASKS];

	logic [7:0]           full_cap_q, srv_period_q, cap_q, ramt_q;
	logic [WIDE-1:0]      rtime_q;
	logic [TIME_BITS-1:0] time_q;
	logic                 act_q;
	logic [IDX_W-1:0]     scan_q;
	logic [CNT_W-1:0]     nadm_q;
	logic                 sel_v_q, refill_q;
	logic [IDX_W-1:0]     sel_q;
	logic [MAX_TASKS-1:0] miss_q;

	logic [WIDE-1:0]      time_ext, arr_ext, dl_sum, rt_sum;
	logic                 ready, better;
	logic [8:0]           cap_sum;
	logic                 sel_aper;
	logic [TIME_BITS-1:0] time_nxt;
	logic                 refill_hit, dead_hit;
	logic [MAX_TASKS-1:0] slot_bit;

	assign stat.scan_last = (32'(scan_q) == MAX_TASKS - 1);
	assign time_ext = WIDE'(time_q);
	assign time_nxt = (time_q == TIME_MAX) ? time_q : time_q + 1'b1;
	assign arr_ext  = WIDE'(arrival_q[scan_q]);
	assign dl_sum   = deadline_q[scan_q] + WIDE'(period_q[scan_q]);
	assign rt_sum   = WIDE'(time_nxt) + WIDE'(srv_period_q);
	assign cap_sum  = {1'b0, cap_q} + {1'b0, ramt_q};
	assign sel_aper = sel_v_q && !periodic_q[sel_q];
	assign refill_hit = (time_ext == rtime_q) && (ramt_q != 8'd0);
	assign dead_hit = admitted_q[scan_q] && !(time_ext < deadline_q[scan_q]);
	assign slot_bit = MAX_TASKS'(1) << scan_q;
	assign ready    = admitted_q[scan_q] && (work_q[scan_q] != 8'd0)
		&& (periodic_q[scan_q] || (cap_q != 8'd0));
	assign better   = !sel_v_q || (period_q[scan_q] < period_q[sel_q])
		|| ((period_q[scan_q] == period_q[sel_q]) && (rank_q[scan_q] < rank_q[sel_q]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q     <= '0;
			admitted_q   <= '0;
			full_cap_q   <= 8'd1;
			srv_period_q <= 8'd5;
			cap_q        <= 8'd1;
			ramt_q       <= '0;
			rtime_q      <= WIDE'(5);
			time_q       <= '0;
			act_q        <= 1'b0;
			scan_q       <= '0;
			nadm_q       <= '0;
			sel_v_q      <= 1'b0;
			sel_q        <= '0;
			refill_q     <= 1'b0;
			miss_q       <= '0;
			now_tick     <= '0;
			ran_valid    <= 1'b0;
			ran_slot     <= '0;
			ran_aperiodic <= 1'b0;
			miss_mask    <= '0;
			capacity_now <= '0;
			replenished  <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_FULL_CAPACITY) full_cap_q <= cfg_data;
				else if (cfg_idx == REG_SERVER_PERIOD) srv_period_q <= cfg_data;
			end
			if (cmd.load && (32'(in_slot) < MAX_TASKS)) begin
				for (int i = 0; i < MAX_TASKS; i++)
					if (admitted_q[IDX_W'(i)] && admitted_q[IDX_W'(in_slot)]
						&& rank_q[i] > rank_q[IDX_W'(in_slot)])
						rank_q[i] <= rank_q[i] - 1'b1;
				admitted_q[IDX_W'(in_slot)] <= 1'b0;
				loaded_q[IDX_W'(in_slot)]   <= 1'b1;
				exec_q[IDX_W'(in_slot)]     <= in_exec;
				period_q[IDX_W'(in_slot)]   <= in_period;
				arrival_q[IDX_W'(in_slot)]  <= in_arrival;
				periodic_q[IDX_W'(in_slot)] <= in_periodic;
			end
			if (cmd.clr_scan) begin
				scan_q  <= '0;
				nadm_q  <= CNT_W'($countones(admitted_q));
				sel_v_q <= 1'b0;
				miss_q  <= '0;
			end else if (cmd.admit_step || cmd.select_step || cmd.dead_step) begin
				scan_q <= stat.scan_last ? '0 : scan_q + 1'b1;
			end
			if (cmd.admit_step && loaded_q[scan_q] && !admitted_q[scan_q]
				&& arr_ext <= time_ext) begin
				admitted_q[scan_q] <= 1'b1;
				rank_q[scan_q]     <= IDX_W'(nadm_q);
				nadm_q             <= nadm_q + 1'b1;
				work_q[scan_q]     <= exec_q[scan_q];
				deadline_q[scan_q] <= WIDE'(period_q[scan_q]);
			end
			if (cmd.refill) begin
				refill_q <= refill_hit;
				if (refill_hit) begin
					cap_q  <= cap_sum[8] ? 8'hFF : cap_sum[7:0];
					ramt_q <= '0;
				end
			end
			if (cmd.select_step && ready && better) begin
				sel_v_q <= 1'b1;
				sel_q   <= scan_q;
			end
			if (cmd.run) begin
				time_q <= time_nxt;
				if (sel_v_q) work_q[sel_q] <= work_q[sel_q] - 8'd1;
				act_q <= sel_aper;
				if (sel_aper) begin
					cap_q <= cap_q - 8'd1;
					if (!act_q) rtime_q <= rt_sum;
				end else if (act_q) begin
					ramt_q <= (cap_q < full_cap_q) ? full_cap_q - cap_q : 8'd0;
				end
			end
			if (cmd.dead_step && dead_hit) begin
				if (work_q[scan_q] != 8'd0) miss_q[scan_q] <= 1'b1;
				if (periodic_q[scan_q]) begin
					work_q[scan_q]     <= exec_q[scan_q];
					deadline_q[scan_q] <= (dl_sum < deadline_q[scan_q]) ? WIDE_MAX : dl_sum;
				end
			end
			if (cmd.emit) begin
				now_tick      <= time_q;
				ran_valid     <= sel_v_q;
				ran_slot      <= sel_v_q ? SLOT_W'(sel_q) : '0;
				ran_aperiodic <= sel_aper;
				miss_mask     <= (cmd.dead_step && dead_hit && work_q[scan_q] != 8'd0)
					? (miss_q | slot_bit) : miss_q;
				capacity_now  <= cap_q;
				replenished   <= refill_q;
			end
		end
	end

endmodule

FILE: src/rmss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmss_ctrl
// Sequencer for load and tick words, with output word handshake.
// ----------------------------------------------------------------------------
module rmss_ctrl import rmss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  logic     is_tick,
	output logic     m_tvalid,
	input  logic     m_tready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	state_t state_q;
	logic   out_v_q;
	logic   emit_ok;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_v_q;
	assign emit_ok  = !out_v_q || m_tready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load     = s_tvalid && !is_tick;
				cmd.clr_scan = s_tvalid && is_tick;
			end
			ST_ADMIT:  cmd.admit_step = 1'b1;
			ST_REFILL: cmd.refill = 1'b1;
			ST_SELECT: cmd.select_step = 1'b1;
			ST_RUN:    cmd.run = 1'b1;
			ST_DEAD: begin
				cmd.dead_step = !stat.scan_last || emit_ok;
				cmd.emit      = stat.scan_last && emit_ok;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= cmd.emit ? 1'b1 : (m_tready ? 1'b0 : out_v_q);
			case (state_q)
				ST_IDLE:   if (s_tvalid && is_tick) state_q <= ST_ADMIT;
				ST_ADMIT:  if (stat.scan_last) state_q <= ST_REFILL;
				ST_REFILL: state_q <= ST_SELECT;
				ST_SELECT: if (stat.scan_last) state_q <= ST_RUN;
				ST_RUN:    state_q <= ST_DEAD;
				ST_DEAD:   if (cmd.emit) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: src/rate_monotonic_sporadic_server_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rate_monotonic_sporadic_server_core
// Rate-monotonic task scheduler with a sporadic server for aperiodic work.
// ----------------------------------------------------------------------------
// Channel  Dir  Word contents
// s_axis   in   tuser: opcode; tdata: slot, exec, task_period, arrival, periodic
// m_axis   out  tdata: now_tick, ran_valid, ran_slot, ran_aperiodic, miss_mask,
//               capacity_now, replenished
// cfg      in   cfg_we, cfg_idx, cfg_data
//
// A load word is written in idle. A tick word runs three sweeps over the slot
// table (admit, select, deadline), one slot per cycle unless the output stalls.
// Reset clears all control state; no clearing pass is needed.
// A stalled output word holds the last sweep step until it is taken.
// ----------------------------------------------------------------------------
module rate_monotonic_sporadic_server_core import rmss_pkg::*; #(
	parameter int unsigned MAX_TASKS = 8,
	parameter int unsigned TIME_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // slot, exec, task_period, arrival, periodic
	input  logic        s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // now_tick, ran_valid, ran_slot, ran_aperiodic,
	                                   // miss_mask, capacity_now, replenished
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [7:0]  cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	logic [TIME_BITS-1:0] now_tick;
	logic                 ran_valid, ran_aperiodic, replenished;
	logic [2:0]           ran_slot;
	logic [MAX_TASKS-1:0] miss_mask;
	logic [7:0]           capacity_now;

	rmss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.is_tick  (s_axis_tuser),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	rmss_datapath #(.MAX_TASKS(MAX_TASKS), .TIME_BITS(TIME_BITS), .SLOT_W(3)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_slot      (s_axis_tdata[2:0]),
		.in_exec      (s_axis_tdata[10:3]),
		.in_period    (s_axis_tdata[18:11]),
		.in_arrival   (s_axis_tdata[34:19]),
		.in_periodic  (s_axis_tdata[35]),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.now_tick     (now_tick),
		.ran_valid    (ran_valid),
		.ran_slot     (ran_slot),
		.ran_aperiodic(ran_aperiodic),
		.miss_mask    (miss_mask),
		.capacity_now (capacity_now),
		.replenished  (replenished)
	);

	logic [7:0] miss8;
	always_comb begin
		miss8 = '0;
		for (int i = 0; i < 8; i++)
			if (i < MAX_TASKS) miss8[i] = miss_mask[i];
	end

	assign m_axis_tdata = {2'd0, replenished, capacity_now, miss8, ran_aperiodic,
		ran_slot, ran_valid, 16'(now_tick)};

	a_single_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid && !m_axis_tready && cmd.emit))
		else $error("emit while output busy");
	a_no_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run |-> !s_axis_tready)
		else $error("input taken mid-tick");
	a_idle_ranslot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[16]) |-> (m_axis_tdata[19:17] == 3'd0))
		else $error("ran_slot set on idle tick");

endmodule
